@@ src/mllo_pkg.sv @@
`timescale 1ns / 1ps

package mllo_pkg;

  // Field and register widths.
  localparam int CH_W       = 8;
  localparam int PIX_W      = 4 * CH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int LEVEL_W    = 5;
  localparam int CELL_W     = 8;
  localparam int SCALE_W    = 4;
  localparam int DIGIT_W    = 4;
  localparam int SUM_W      = 16;

  // Default for the largest frame side.
  localparam int DEF_MAX_SIDE = 8192;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_NUMBER   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_ENABLE = 2'd3;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 14'd64;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 14'd64;
  localparam logic [LEVEL_W-1:0]    RST_LEVEL_NUMBER = 5'd0;
  localparam logic                  RST_ENABLE       = 1'b1;

  // Overlay constants.
  localparam int SCALE_DIV  = 192;
  localparam int SCALE_MAX  = 10;
  localparam int SMALL_SIDE = 9;
  localparam logic [CH_W-1:0] ALPHA_CELL  = 8'd105;
  localparam logic [CH_W-1:0] ALPHA_SMALL = 8'd190;
  localparam logic [CH_W-1:0] CH_FULL     = 8'd255;
  localparam logic [SUM_W-1:0] ROUND_BIAS = 16'd127;

  // The quotient of a cell offset by the scale takes one bit per step.
  localparam int DIV_STEPS = CELL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // One row of the 5x7 font, bit 4 is the leftmost column.
  function automatic logic [4:0] glyph_row(input logic [DIGIT_W-1:0] d, input logic [2:0] r);
    logic [34:0] rows;
    case (d)
      4'd0: rows = {5'h0E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h0E};
      4'd1: rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0C, 5'h04};
      4'd2: rows = {5'h1F, 5'h08, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      4'd3: rows = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      4'd4: rows = {5'h02, 5'h02, 5'h1F, 5'h12, 5'h0A, 5'h06, 5'h02};
      4'd5: rows = {5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F};
      4'd6: rows = {5'h0E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h0E};
      4'd7: rows = {5'h08, 5'h08, 5'h08, 5'h04, 5'h02, 5'h01, 5'h1F};
      4'd8: rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      4'd9: rows = {5'h0E, 5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0E};
      default: rows = '0;
    endcase
    if (r > 3'd6) begin
      return 5'h00;
    end
    return rows[r*5 +: 5];
  endfunction

  // Palette color packed as blue, green, red from the top down.
  function automatic logic [3*CH_W-1:0] tint_rgb(input logic [DIGIT_W-1:0] idx);
    case (idx)
      4'd0: return {8'd52,  8'd64,  8'd235};
      4'd1: return {8'd26,  8'd159, 8'd255};
      4'd2: return {8'd21,  8'd204, 8'd250};
      4'd3: return {8'd94,  8'd197, 8'd34};
      4'd4: return {8'd166, 8'd184, 8'd20};
      4'd5: return {8'd233, 8'd165, 8'd14};
      4'd6: return {8'd246, 8'd130, 8'd59};
      4'd7: return {8'd246, 8'd92,  8'd139};
      4'd8: return {8'd239, 8'd70,  8'd217};
      4'd9: return {8'd153, 8'd72,  8'd236};
      default: return '0;
    endcase
  endfunction

  // Exact division by 255 for sums up to 65279, which covers every blend sum.
  function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = s + {8'd0, s[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

@@ src/mllo_ctrl.sv @@
`timescale 1ns / 1ps

module mllo_ctrl
  import mllo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREP   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_FINISH;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ src/mllo_datapath.sv @@
`timescale 1ns / 1ps

module mllo_datapath
  import mllo_pkg::*;
#(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]      in_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      out_data_o,
  output logic                  out_last_o
);

  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int SZ_W   = SIDE_W + 1;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] width_cfg_q, height_cfg_q;
  logic [LEVEL_W-1:0]    level_q;
  logic                  enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= RST_FRAME_WIDTH;
      height_cfg_q <= RST_FRAME_HEIGHT;
      level_q      <= RST_LEVEL_NUMBER;
      enable_q     <= RST_ENABLE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:    width_cfg_q  <= cfg_data_i;
        REG_FRAME_HEIGHT:   height_cfg_q <= cfg_data_i;
        REG_LEVEL_NUMBER:   level_q      <= cfg_data_i[LEVEL_W-1:0];
        REG_OVERLAY_ENABLE: enable_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Frame and cell geometry, derived from the registers and registered again.
  logic [SZ_W-1:0]      w_c, h_c, mind_c, w_q, h_q;
  logic [SCALE_W-1:0]   sc_c, sc_q;
  logic [1:0]           tens_c;
  logic [DIGIT_W-1:0]   ones_c, d0_q, d1_q;
  logic                 two_c, two_q, small_c, small_q;
  logic [CELL_W-1:0]    tx_c, ty_c, cw_c, ch_c, tx_q, ty_q, cw_q, ch_q;
  logic [3*CH_W-1:0]    tint_q;

  always_comb begin
    if (width_cfg_q == '0) begin
      w_c = SZ_W'(1);
    end else if (32'(width_cfg_q) > MAX_SIDE) begin
      w_c = SZ_W'(MAX_SIDE);
    end else begin
      w_c = SZ_W'(width_cfg_q);
    end
    if (height_cfg_q == '0) begin
      h_c = SZ_W'(1);
    end else if (32'(height_cfg_q) > MAX_SIDE) begin
      h_c = SZ_W'(MAX_SIDE);
    end else begin
      h_c = SZ_W'(height_cfg_q);
    end
    mind_c  = (w_c < h_c) ? w_c : h_c;
    small_c = 32'(mind_c) < SMALL_SIDE;
    // Scale is the smaller frame side over 192, clamped to one through ten.
    sc_c = SCALE_W'(1);
    for (int k = 2; k <= SCALE_MAX; k++) begin
      if (32'(mind_c) >= k * SCALE_DIV) begin
        sc_c = SCALE_W'(k);
      end
    end
    if (level_q >= 5'd30) begin
      tens_c = 2'd3;
    end else if (level_q >= 5'd20) begin
      tens_c = 2'd2;
    end else if (level_q >= 5'd10) begin
      tens_c = 2'd1;
    end else begin
      tens_c = 2'd0;
    end
    ones_c = DIGIT_W'(level_q - 5'({3'd0, tens_c}) * 5'd10);
    two_c  = level_q >= 5'd10;
    // The cell is always 24 by 18 scale units; the label sits centered in it.
    tx_c = two_c ? CELL_W'((8'd13 * 8'(sc_c)) >> 1) : CELL_W'((8'd19 * 8'(sc_c)) >> 1);
    ty_c = CELL_W'((8'd11 * 8'(sc_c)) >> 1);
    cw_c = CELL_W'(8'd24 * 8'(sc_c));
    ch_c = CELL_W'(8'd18 * 8'(sc_c));
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_c;
    h_q     <= h_c;
    sc_q    <= sc_c;
    small_q <= small_c;
    two_q   <= two_c;
    d0_q    <= two_c ? DIGIT_W'(tens_c) : ones_c;
    d1_q    <= ones_c;
    tx_q    <= tx_c;
    ty_q    <= ty_c;
    cw_q    <= cw_c;
    ch_q    <= ch_c;
    tint_q  <= tint_rgb(ones_c);
  end

  // Position counters.
  logic [SIDE_W-1:0] col_q, row_q;
  logic [CELL_W-1:0] ccol_q, crow_q;
  logic [SZ_W-1:0]   col_inc, row_inc;
  logic [CELL_W:0]   ccol_inc, crow_inc;
  logic              row_end, frame_last;

  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign row_inc    = {1'b0, row_q} + 1'b1;
  assign ccol_inc   = {1'b0, ccol_q} + 1'b1;
  assign crow_inc   = {1'b0, crow_q} + 1'b1;
  assign row_end    = col_inc >= w_q;
  assign frame_last = row_end && (row_inc >= h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ccol_q <= '0;
      crow_q <= '0;
    end else if (cmd_i.finish) begin
      if (row_end) begin
        col_q  <= '0;
        ccol_q <= '0;
        if (frame_last) begin
          row_q  <= '0;
          crow_q <= '0;
        end else begin
          row_q  <= row_inc[SIDE_W-1:0];
          crow_q <= (crow_inc >= {1'b0, ch_q}) ? '0 : crow_inc[CELL_W-1:0];
        end
      end else begin
        col_q  <= col_inc[SIDE_W-1:0];
        ccol_q <= (ccol_inc >= {1'b0, cw_q}) ? '0 : ccol_inc[CELL_W-1:0];
      end
    end
  end

  // Pixel capture.
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q <= in_data_i;
    end
  end

  // Blend sums and label offsets, set up before the division steps.
  logic [CH_W-1:0]  alpha_c, inv_c;
  logic [SUM_W-1:0] sum_c [3];
  logic [SUM_W-1:0] sum_q [3];
  logic             xok_q, yok_q;

  always_comb begin
    alpha_c = small_q ? ALPHA_SMALL : ALPHA_CELL;
    inv_c   = CH_FULL - alpha_c;
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = 16'(pix_q[c*CH_W +: CH_W]) * 16'(inv_c)
               + 16'(tint_q[c*CH_W +: CH_W]) * 16'(alpha_c) + ROUND_BIAS;
    end
  end

  // Restoring division of the two offsets by the scale, one quotient bit a step.
  logic [CELL_W-1:0]  qx_q, qy_q;
  logic [SCALE_W-1:0] rx_q, ry_q;
  logic [SCALE_W:0]   rx_sh, ry_sh;
  logic               bx_c, by_c;

  assign rx_sh = {rx_q, qx_q[CELL_W-1]};
  assign ry_sh = {ry_q, qy_q[CELL_W-1]};
  assign bx_c  = rx_sh >= {1'b0, sc_q};
  assign by_c  = ry_sh >= {1'b0, sc_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_c[c];
      end
      xok_q <= ccol_q >= tx_q;
      yok_q <= crow_q >= ty_q;
      qx_q  <= ccol_q - tx_q;
      qy_q  <= crow_q - ty_q;
      rx_q  <= '0;
      ry_q  <= '0;
    end else if (cmd_i.div_step) begin
      rx_q <= bx_c ? SCALE_W'(rx_sh - {1'b0, sc_q}) : rx_sh[SCALE_W-1:0];
      ry_q <= by_c ? SCALE_W'(ry_sh - {1'b0, sc_q}) : ry_sh[SCALE_W-1:0];
      qx_q <= {qx_q[CELL_W-2:0], bx_c};
      qy_q <= {qy_q[CELL_W-2:0], by_c};
    end
  end

  // Glyph lookup: white face and its shadow one scale unit right and down.
  logic               white, black;
  logic [CELL_W-1:0]  base;
  logic [DIGIT_W-1:0] dig;
  logic [2:0]         gcol;
  logic [4:0]         gbits;

  always_comb begin
    white = 1'b0;
    black = 1'b0;
    base  = '0;
    dig   = '0;
    gcol  = '0;
    gbits = '0;
    for (int i = 0; i < 2; i++) begin
      base = CELL_W'(6 * i);
      dig  = (i == 0) ? d0_q : d1_q;
      if (((i == 0) || two_q) && xok_q && yok_q) begin
        if ((qx_q >= base) && (qx_q < base + 8'd5) && (qy_q < 8'd7)) begin
          gcol  = 3'(qx_q - base);
          gbits = glyph_row(dig, qy_q[2:0]);
          if (gbits[3'd4 - gcol]) begin
            white = 1'b1;
          end
        end
        if ((qx_q >= base + 8'd1) && (qx_q < base + 8'd6) &&
            (qy_q >= 8'd1) && (qy_q < 8'd8)) begin
          gcol  = 3'(qx_q - base - 8'd1);
          gbits = glyph_row(dig, 3'(qy_q - 8'd1));
          if (gbits[3'd4 - gcol]) begin
            black = 1'b1;
          end
        end
      end
    end
  end

  // Final color selection.
  logic [PIX_W-1:0] res_c;

  always_comb begin
    res_c = pix_q;
    if (enable_q) begin
      for (int c = 0; c < 3; c++) begin
        if (!small_q && white) begin
          res_c[c*CH_W +: CH_W] = CH_FULL;
        end else if (!small_q && black) begin
          res_c[c*CH_W +: CH_W] = '0;
        end else begin
          res_c[c*CH_W +: CH_W] = div255(sum_q[c]);
        end
      end
    end
  end

  // Output register; it frees in the same cycle as a transfer out.
  logic             out_valid_q;
  logic [PIX_W-1:0] out_data_q;
  logic             out_last_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= res_c;
      out_last_q <= frame_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

@@ src/mip_level_label_overlay_core.sv @@
`timescale 1ns / 1ps

// Level label overlay for a raster-order RGBA pixel stream.
// Pixels enter on the s_axis channel and leave on the m_axis channel in the
// same order, one result per pixel; tlast marks the last pixel of a frame.
// Frame size, level number and enable are written on the cfg channel, which
// is always ready; write it only while no pixel is in flight.
// Each pixel goes through these steps in order: it is accepted, the blend
// sums and label offsets are set up, the two cell offsets are divided
// bit-serially by the font scale, and the color is picked and loaded into
// the output register. A new pixel is accepted only after the last one has
// loaded the output register, so pixels are not overlapped inside the block.
// The output register decouples the two sides: the next pixel is accepted and
// worked on while a result waits; when the receiver stalls, the finished
// pixel waits in its last step until the output register frees.
// Reset clears the position counters, empties the output register and loads
// the registers with a 64 by 64 frame, level zero and the overlay enabled.
module mip_level_label_overlay_core
  import mllo_pkg::*;
#(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input: in_red, in_green, in_blue, in_alpha from bit 0 up.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,
  // Pixel output: out_red, out_green, out_blue, out_alpha from bit 0 up.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,
  // frame_end.
  output logic                  m_axis_tlast
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  mllo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mllo_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // The block is busy right after taking a pixel.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a pixel is still in work");

  // A result is loaded only from the final step of a busy pixel.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a pixel in work");

  // At most one datapath command per cycle.
  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.prep, cmd.div_step, cmd.finish}))
    else $error("controller issued several commands at once");

  // The output register is loaded only when it is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

endmodule
